@@ rtl/core/assert_macros.svh @@
// Assertion helpers; clk and rst_n are taken from the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/u16u8_pkg.sv @@
package u16u8_pkg;

    localparam logic [15:0] SUR_HI_BASE = 16'hD800;
    localparam logic [15:0] SUR_LO_BASE = 16'hDC00;
    localparam logic [15:0] SUR_END     = 16'hE000;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int RUN_MAX         = 6;
    localparam int RUN_LEN_W       = 3;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } utf8_seq_t;

    // One step's worth of output bytes, first byte at index 0
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_LEN_W-1:0]    count;
        logic                    done;
    } run_job_t;

    function automatic utf8_seq_t encode_cp(input logic [20:0] cp);
        utf8_seq_t seq;
        seq = '0;
        if (cp < 21'h80) begin
            seq.bytes[0] = cp[7:0];
            seq.len      = 3'd1;
        end
        else if (cp < 21'h800) begin
            seq.bytes[0] = {3'b110, cp[10:6]};
            seq.bytes[1] = {2'b10, cp[5:0]};
            seq.len      = 3'd2;
        end
        else if (cp < 21'h10000) begin
            seq.bytes[0] = {4'b1110, cp[15:12]};
            seq.bytes[1] = {2'b10, cp[11:6]};
            seq.bytes[2] = {2'b10, cp[5:0]};
            seq.len      = 3'd3;
        end
        else begin
            seq.bytes[0] = {5'b11110, cp[20:18]};
            seq.bytes[1] = {2'b10, cp[17:12]};
            seq.bytes[2] = {2'b10, cp[11:6]};
            seq.bytes[3] = {2'b10, cp[5:0]};
            seq.len      = 3'd4;
        end
        return seq;
    endfunction

endpackage

@@ rtl/core/utf16be_to_utf8_transcoder_unit.sv @@
// Channel   Handshake            Payload
// input     in_valid/in_stall    in_byte[7:0], stream_end
// output    out_valid/out_stall  out_byte[7:0], run_last, text_done
//
// An input byte is taken every cycle while the run queue has room; each byte
// becomes a run of 0 to 6 UTF-8 bytes, queued whole.
// The output serializer sends one byte per cycle while out_stall is low.
// rst_n clears the unit assembler, the held surrogate, the queue and the
// output valid flag at once. An output stall holds the output register and
// backs up into the queue; in_stall rises only once the queue is full.
module utf16be_to_utf8_transcoder_unit
#(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       stream_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       text_done
);
    import u16u8_pkg::*;

    run_job_t push_job;
    run_job_t head_job;
    logic     push;
    logic     pop;
    logic     q_empty;
    logic     q_full;
    logic     accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    u16u8_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .stream_end (stream_end),
        .push       (push),
        .push_job   (push_job)
    );

    u16u8_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    u16u8_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_done (text_done)
    );

endmodule

@@ rtl/core/u16u8_front.sv @@
module u16u8_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                stream_end,
    output logic                push,
    output u16u8_pkg::run_job_t push_job
);
    import u16u8_pkg::*;

    logic [7:0]  upper_reg, upper_next;
    logic        have_upper_reg, have_upper_next;
    logic [9:0]  hs_reg, hs_next;
    logic        have_hs_reg, have_hs_next;

    logic [15:0] unit;
    logic        flush;
    logic        main_valid;
    logic [20:0] main_cp;
    logic [20:0] flush_cp;
    utf8_seq_t   flush_seq;
    utf8_seq_t   main_seq;

    assign unit     = {upper_reg, in_byte};
    assign flush_cp = 21'(SUR_HI_BASE) + 21'(hs_reg);

    always_comb
    begin
        upper_next      = upper_reg;
        have_upper_next = have_upper_reg;
        hs_next         = hs_reg;
        have_hs_next    = have_hs_reg;
        flush           = 1'b0;
        main_valid      = 1'b0;
        main_cp         = 21'(unit);
        if (!have_upper_reg)
        begin
            if (stream_end)
            begin
                // drop the odd byte, flush any held surrogate
                flush = have_hs_reg;
            end
            else
            begin
                upper_next      = in_byte;
                have_upper_next = 1'b1;
            end
        end
        else
        begin
            upper_next      = '0;
            have_upper_next = 1'b0;
            if (have_hs_reg && (unit inside {[SUR_LO_BASE:SUR_END - 16'd1]}))
            begin
                main_cp      = SUPP_BASE + {1'b0, hs_reg, unit[9:0]};
                main_valid   = 1'b1;
                hs_next      = '0;
                have_hs_next = 1'b0;
            end
            else
            begin
                flush        = have_hs_reg;
                hs_next      = '0;
                have_hs_next = 1'b0;
                if ((unit inside {[SUR_HI_BASE:SUR_LO_BASE - 16'd1]}) && !stream_end)
                begin
                    hs_next      = unit[9:0];
                    have_hs_next = 1'b1;
                end
                else
                begin
                    main_valid = 1'b1;
                end
            end
        end
        if (stream_end)
        begin
            upper_next      = '0;
            have_upper_next = 1'b0;
            hs_next         = '0;
            have_hs_next    = 1'b0;
        end
    end

    assign flush_seq = encode_cp(flush_cp);
    assign main_seq  = encode_cp(main_cp);

    always_comb
    begin
        push_job.done  = stream_end;
        push_job.count = (flush ? RUN_LEN_W'(3) : '0) + (main_valid ? main_seq.len : '0);
        if (flush)
        begin
            push_job.bytes = {main_seq.bytes[2:0], flush_seq.bytes[2:0]};
        end
        else
        begin
            push_job.bytes = {16'h0000, main_seq.bytes};
        end
    end

    assign push = accept && (push_job.count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg      <= '0;
            have_upper_reg <= 1'b0;
            hs_reg         <= '0;
            have_hs_reg    <= 1'b0;
        end
        else if (accept)
        begin
            upper_reg      <= upper_next;
            have_upper_reg <= have_upper_next;
            hs_reg         <= hs_next;
            have_hs_reg    <= have_hs_next;
        end
    end

endmodule

@@ rtl/core/u16u8_queue.sv @@
module u16u8_queue
#(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  u16u8_pkg::run_job_t push_job,
    input  logic                pop,
    output u16u8_pkg::run_job_t head_job,
    output logic                empty,
    output logic                full
);
    import u16u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    run_job_t             store [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign head_job = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/u16u8_back.sv @@
module u16u8_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  u16u8_pkg::run_job_t head_job,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                run_last,
    output logic                text_done
);
    import u16u8_pkg::*;

    logic [RUN_LEN_W-1:0] idx_reg, idx_next;
    logic                 valid_reg, valid_next;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic                 done_reg;
    logic                 load;
    logic                 take;
    logic                 at_last;

    // refill the output register when empty or being taken
    assign load    = !valid_reg || !out_stall;
    assign take    = load && !empty;
    assign at_last = (idx_reg == head_job.count - 1'b1);
    assign pop     = take && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = !empty;
        end
        if (take)
        begin
            idx_next = at_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= head_job.bytes[idx_reg];
            last_reg <= at_last;
            done_reg <= at_last && head_job.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign run_last  = last_reg;
    assign text_done = done_reg;

endmodule

@@ rtl/core/u16u8_checker.sv @@
`include "assert_macros.svh"

module u16u8_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       stream_end,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       text_done
);

    // a stalled request keeps its byte
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte))

    // end of text only ever closes a run
    `ASSERT_ALWAYS(a_done_on_last, !(out_valid && text_done) || run_last)

    // the rest of a run follows without a gap
    `ASSERT_NEXT(a_run_no_gap, out_valid && !out_stall && !run_last, out_valid)

    // a full queue implies the output side already holds a byte
    `ASSERT_ALWAYS(a_stall_backed, !in_stall || out_valid)

endmodule

bind utf16be_to_utf8_transcoder_unit u16u8_checker u_checker (.*);

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import u16u8_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 380;
    localparam int DRAIN_CYCLES = 24;
    localparam int SCRIPT_LEN   = 28;
    localparam int PRED         = -1;
    localparam int PRINT_CAP    = 60;

    typedef struct packed {
        logic [7:0]      b;
        logic            fin;
        int              n;
        logic [0:5][7:0] exp;
    } directed_row_t;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
    } stim_byte_t;

    typedef struct packed {
        logic [7:0] val;
        logic       last;
        logic       done;
    } utf8_byte_t;

    // n = PRED leaves the row to the predictor; otherwise exp holds n bytes
    localparam directed_row_t SCRIPT [SCRIPT_LEN] = '{
        '{8'h00, 1'b0, PRED, 48'h0},
        '{8'h00, 1'b0, 1,    48'h00_0000000000},
        '{8'h00, 1'b0, PRED, 48'h0},
        '{8'h80, 1'b0, 2,    48'hC280_00000000},
        '{8'h07, 1'b0, PRED, 48'h0},
        '{8'hFF, 1'b0, 2,    48'hDFBF_00000000},
        '{8'hFF, 1'b0, PRED, 48'h0},
        '{8'hFF, 1'b0, 3,    48'hEFBFBF_000000},
        '{8'hD8, 1'b0, PRED, 48'h0},
        '{8'h00, 1'b0, 0,    48'h0},
        '{8'hDC, 1'b0, PRED, 48'h0},
        '{8'h00, 1'b0, 4,    48'hF0908080_0000},
        '{8'hDB, 1'b0, PRED, 48'h0},
        '{8'hFF, 1'b0, 0,    48'h0},
        '{8'hDF, 1'b0, PRED, 48'h0},
        '{8'hFF, 1'b0, 4,    48'hF48FBFBF_0000},
        '{8'hDC, 1'b0, PRED, 48'h0},
        '{8'h00, 1'b0, 3,    48'hEDB080_000000},
        '{8'hD8, 1'b0, PRED, 48'h0},
        '{8'h00, 1'b0, 0,    48'h0},
        '{8'hFF, 1'b0, PRED, 48'h0},
        '{8'hFF, 1'b0, 6,    48'hEDA080EFBFBF},
        '{8'hD8, 1'b0, PRED, 48'h0},
        '{8'h01, 1'b1, 3,    48'hEDA081_000000},
        '{8'hDB, 1'b0, PRED, 48'h0},
        '{8'hC0, 1'b0, 0,    48'h0},
        '{8'h55, 1'b1, 3,    48'hEDAF80_000000},
        '{8'h12, 1'b1, 0,    48'h0}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       stream_end;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;

    // predictor state
    logic [7:0] pend_upper;
    logic       pend_valid;
    logic [9:0] hi_bits;
    logic       hi_valid;

    logic [7:0] step_bytes [$];
    utf8_byte_t utf8_due [$];
    stim_byte_t stim [$];

    int  mismatches = 0;
    int  cycles     = 0;
    int  sent       = 0;
    int  taken      = 0;
    wire calm       = (sent >= 160) && (sent < 280);

    utf16be_to_utf8_transcoder_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .stream_end (stream_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .text_done  (text_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    function automatic void put_cp(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            step_bytes.push_back(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            step_bytes.push_back({3'b110, cp[10:6]});
            step_bytes.push_back({2'b10, cp[5:0]});
        end
        else if (cp < SUPP_BASE)
        begin
            step_bytes.push_back({4'b1110, cp[15:12]});
            step_bytes.push_back({2'b10, cp[11:6]});
            step_bytes.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            step_bytes.push_back({5'b11110, cp[20:18]});
            step_bytes.push_back({2'b10, cp[17:12]});
            step_bytes.push_back({2'b10, cp[11:6]});
            step_bytes.push_back({2'b10, cp[5:0]});
        end
    endfunction

    // Leave the UTF-8 bytes caused by one request in step_bytes
    function automatic void transcode_byte(input logic [7:0] b, input logic fin);
        logic [15:0] unit;
        logic [20:0] held_cp;
        step_bytes.delete();
        held_cp = {5'd0, SUR_HI_BASE | {6'd0, hi_bits}};
        if (!pend_valid)
        begin
            // odd trailing byte: drop it, flush any held surrogate
            if (fin)
            begin
                if (hi_valid)
                    put_cp(held_cp);
            end
            else
            begin
                pend_upper = b;
                pend_valid = 1'b1;
            end
        end
        else
        begin
            unit       = {pend_upper, b};
            pend_valid = 1'b0;
            pend_upper = 8'h00;
            if (hi_valid && unit >= SUR_LO_BASE && unit < SUR_END)
            begin
                put_cp(SUPP_BASE + {1'b0, hi_bits, 10'd0} + {5'd0, unit - SUR_LO_BASE});
                hi_valid = 1'b0;
                hi_bits  = 10'd0;
            end
            else
            begin
                if (hi_valid)
                begin
                    put_cp(held_cp);
                    hi_valid = 1'b0;
                    hi_bits  = 10'd0;
                end
                if (unit >= SUR_HI_BASE && unit < SUR_LO_BASE && !fin)
                begin
                    hi_bits  = unit[9:0];
                    hi_valid = 1'b1;
                end
                else
                begin
                    put_cp({5'd0, unit});
                end
            end
        end
        if (fin)
        begin
            pend_upper = 8'h00;
            pend_valid = 1'b0;
            hi_bits    = 10'd0;
            hi_valid   = 1'b0;
        end
    endfunction

    function automatic void add_unit(input logic [15:0] unit, input logic fin);
        stim.push_back('{unit[15:8], 1'b0});
        stim.push_back('{unit[7:0], fin});
    endfunction

    function automatic logic [15:0] pick_unit();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            return 16'($urandom_range(0, 16'h7F));
        else if (pick < 50)
            return 16'($urandom_range(16'h80, 16'h7FF));
        else if (pick < 70)
            return $urandom_range(0, 1) ? 16'($urandom_range(16'h800, 16'hD7FF))
                                        : 16'($urandom_range(16'hE000, 16'hFFFF));
        else if (pick < 80)
            return 16'($urandom_range(16'hD800, 16'hDBFF));
        else if (pick < 88)
            return 16'($urandom_range(16'hDC00, 16'hDFFF));
        else
            return 16'($urandom);
    endfunction

    task automatic send_byte(input stim_byte_t req);
        while (!calm && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= req.b;
        stream_end <= req.fin;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("utf16be_to_utf8_transcoder_unit regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= !calm && ($urandom_range(99) < 21);
    end

    // Check outputs first, then predict for the request taken at this edge
    always @(posedge clk)
    begin
        utf8_byte_t    want;
        directed_row_t row;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (utf8_due.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected byte %h", out_byte));
                end
                else
                begin
                    want = utf8_due.pop_front();
                    if (out_byte !== want.val)
                        flag_mismatch($sformatf("out_byte %h, want %h", out_byte, want.val));
                    if (run_last !== want.last)
                        flag_mismatch($sformatf("run_last %b, want %b", run_last, want.last));
                    if (text_done !== want.done)
                        flag_mismatch($sformatf("text_done %b, want %b",
                                                text_done, want.done));
                end
            end
            if (in_valid && !in_stall)
            begin
                transcode_byte(in_byte, stream_end);
                if (taken < SCRIPT_LEN && SCRIPT[taken].n != PRED)
                begin
                    row = SCRIPT[taken];
                    step_bytes.delete();
                    for (int k = 0; k < row.n; k++)
                        step_bytes.push_back(row.exp[k]);
                end
                foreach (step_bytes[k])
                begin
                    want.val  = step_bytes[k];
                    want.last = (k == step_bytes.size() - 1);
                    want.done = want.last && stream_end;
                    utf8_due.push_back(want);
                end
                taken++;
            end
        end
    end

    initial
    begin
        int units;
        int ending;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_byte    <= 8'h00;
        stream_end <= 1'b0;
        out_stall  <= 1'b0;
        pend_upper = 8'h00;
        pend_valid = 1'b0;
        hi_bits    = 10'd0;
        hi_valid   = 1'b0;

        foreach (SCRIPT[k])
            stim.push_back('{SCRIPT[k].b, SCRIPT[k].fin});

        // mostly well-formed texts, with lone surrogates and odd tails mixed in
        while (stim.size() < SCRIPT_LEN + RANDOM_BYTES)
        begin
            units = $urandom_range(1, 8);
            for (int u = 0; u < units; u++)
            begin
                if ($urandom_range(0, 99) < 25)
                begin
                    add_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                    add_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), 1'b0);
                end
                else
                begin
                    add_unit(pick_unit(), 1'b0);
                end
            end
            ending = $urandom_range(0, 9);
            if (ending < 5)
            begin
                stim[stim.size() - 1].fin = 1'b1;
            end
            else if (ending == 5)
            begin
                stim.push_back('{8'($urandom), 1'b1});
            end
            else if (ending == 6)
            begin
                add_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b1);
            end
            else if (ending == 7)
            begin
                add_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                stim.push_back('{8'($urandom), 1'b1});
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim[k])
            send_byte(stim[k]);
        in_valid <= 1'b0;

        while (utf8_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("utf16be_to_utf8_transcoder_unit regression: pass");
        else
            $display("utf16be_to_utf8_transcoder_unit regression: fail");
        $finish;
    end

endmodule
